// File: design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and defaults for the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // Default sizes
    localparam int MAP_BYTES_DEF   = 4096;
    localparam int MAX_REQUEST_DEF = 12;

    // Field widths
    localparam int ADDR_W  = 12;
    localparam int COUNT_W = 4;
    localparam int INDEX_W = 16;
    localparam int UNIT_W  = 15;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 16;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Result status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // Register indexes
    localparam logic [CFG_IW-1:0] CFG_USABLE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_RESERVE = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BASE    = 2'd2;

    // Register reset values
    localparam logic [CFG_DW-1:0] USABLE_RST  = 16'd32768;
    localparam logic              RESERVE_RST = 1'b1;
    localparam logic              BASE_RST    = 1'b0;

    typedef struct packed {
        logic               opcode;
        logic [ADDR_W-1:0]  byte_address;
        logic [7:0]         byte_value;
        logic [COUNT_W-1:0] request_count;
    } bba_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] unit_index;
        logic               status;
        logic               last;
    } bba_result_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_PICK,
        S_COMMIT_RD,
        S_COMMIT_WR,
        S_RESULT
    } bba_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic byte_wr;
        logic load_req;
        logic scan_rd;
        logic scan_pick;
        logic fail_set;
        logic commit_rd;
        logic commit_wr;
        logic emit_single;
    } bba_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic req_write;
        logic req_zero;
        logic req_over;
        logic scan_end;
        logic byte_empty;
        logic req_met;
        logic last_unit;
    } bba_stat_t;

endpackage : bba_pkg

`default_nettype wire

// File: design/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for clear, byte write, scan, commit and result phases.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire bba_stat_t stat,
    output bba_cmd_t       cmd,
    output logic           busy
);

    bba_state_t state_reg;
    bba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && !stat.req_write)
                begin
                    if (stat.req_zero || stat.req_over)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = stat.scan_end ? S_RESULT : S_SCAN_PICK;
            end
            S_SCAN_PICK:
            begin
                priority if (stat.byte_empty)
                begin
                    state_next = S_SCAN_RD;
                end
                else if (stat.req_met)
                begin
                    state_next = S_COMMIT_RD;
                end
                else
                begin
                    state_next = S_SCAN_PICK;
                end
            end
            S_COMMIT_RD:
            begin
                state_next = S_COMMIT_WR;
            end
            S_COMMIT_WR:
            begin
                state_next = stat.last_unit ? S_IDLE : S_COMMIT_RD;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            S_IDLE:
            begin
                busy          = 1'b0;
                cmd.byte_wr   = start && stat.req_write;
                cmd.load_req  = start && !stat.req_write;
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd  = !stat.scan_end;
                cmd.fail_set = stat.scan_end;
            end
            S_SCAN_PICK:
            begin
                cmd.scan_pick = 1'b1;
            end
            S_COMMIT_RD:
            begin
                cmd.commit_rd = 1'b1;
            end
            S_COMMIT_WR:
            begin
                cmd.commit_wr = 1'b1;
            end
            S_RESULT:
            begin
                cmd.emit_single = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule : bba_ctrl

`default_nettype wire

// File: design/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Free map memory, settings, byte scanner, found list and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_datapath
    import bba_pkg::*;
#(
    parameter int MAP_BYTES   = MAP_BYTES_DEF,
    parameter int MAX_REQUEST = MAX_REQUEST_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bba_item_t         request,
    input  wire logic              cfg_valid,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data,
    input  wire bba_cmd_t          cmd,
    output bba_stat_t              stat,
    output bba_result_t            result,
    output logic                   result_valid
);

    localparam int MAP_AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W      = MAP_AW + 1;
    localparam int MAP_BITS   = MAP_BYTES * 8;
    localparam int LIST_DEPTH = (MAX_REQUEST < 15) ? MAX_REQUEST : 15;
    localparam int LIST_AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    // Settings
    logic [CFG_DW-1:0] usable_reg;
    logic              reserve_reg;
    logic              base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usable_reg  <= USABLE_RST;
            reserve_reg <= RESERVE_RST;
            base_reg    <= BASE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_USABLE:  usable_reg  <= cfg_data;
                CFG_RESERVE: reserve_reg <= cfg_data[0];
                CFG_BASE:    base_reg    <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Request latch and limit
    logic [COUNT_W-1:0] want_reg;
    logic [CNT_W-1:0]   limit_bytes_reg;
    logic [2:0]         lim_low_reg;
    logic               status_reg;
    logic [16:0]        lim_clamped;
    logic [16:0]        lim_round;

    assign lim_clamped = (17'(usable_reg) > 17'(MAP_BITS)) ? 17'(MAP_BITS)
                                                           : 17'(usable_reg);
    assign lim_round   = lim_clamped + 17'd7;

    // Control registers
    logic [CNT_W-1:0]   byte_cnt_reg;
    logic [COUNT_W-1:0] got_reg;
    logic [COUNT_W-1:0] emit_idx_reg;
    logic               first_reg;
    logic [7:0]         work_reg;

    // Found list
    logic [UNIT_W-1:0]  found_list [LIST_DEPTH];
    logic [UNIT_W-1:0]  entry;

    assign entry = found_list[emit_idx_reg[LIST_AW-1:0]];

    // Map memory
    logic [7:0]        map_mem [MAP_BYTES];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [MAP_AW-1:0] wr_addr;
    logic [MAP_AW-1:0] rd_addr;
    logic [7:0]        wr_data;
    logic              addr_in_map;

    assign addr_in_map = 32'(request.byte_address) < MAP_BYTES;

    always_comb
    begin
        mem_we = cmd.clear_wr || cmd.commit_wr || (cmd.byte_wr && addr_in_map);
        priority if (cmd.commit_wr)
        begin
            wr_addr = entry[MAP_AW+2:3];
            wr_data = rd_data_reg | (8'h1 << entry[2:0]);
        end
        else if (cmd.byte_wr)
        begin
            wr_addr = request.byte_address[MAP_AW-1:0];
            wr_data = request.byte_value;
        end
        else
        begin
            wr_addr = byte_cnt_reg[MAP_AW-1:0];
            wr_data = 8'h00;
        end
    end

    assign mem_re  = cmd.scan_rd || cmd.commit_rd;
    assign rd_addr = cmd.commit_rd ? entry[MAP_AW+2:3] : byte_cnt_reg[MAP_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // Byte scanner: usable mask, free bits, lowest free bit
    logic [7:0] byte_mask;
    logic [7:0] low_mask;
    logic [7:0] src;
    logic [2:0] pos;
    logic [8:0] low_shift;

    assign low_shift = 9'h1 << lim_low_reg;
    assign low_mask  = 8'(low_shift - 9'h1);

    always_comb
    begin
        byte_mask = FULL_BYTE;
        if (byte_cnt_reg == '0 && reserve_reg)
        begin
            byte_mask[0] = 1'b0;
        end
        if (CNT_W'(byte_cnt_reg + 1'b1) == limit_bytes_reg && lim_low_reg != 3'd0)
        begin
            byte_mask = byte_mask & low_mask;
        end
    end

    always_comb
    begin
        src = first_reg ? (~rd_data_reg & byte_mask) : work_reg;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (src[i])
            begin
                pos = 3'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            want_reg        <= request.request_count;
            limit_bytes_reg <= CNT_W'(lim_round >> 3);
            lim_low_reg     <= lim_clamped[2:0];
            status_reg      <= (32'(request.request_count) > MAX_REQUEST) ? ST_FAIL
                                                                          : ST_OK;
        end
        else if (cmd.fail_set)
        begin
            status_reg <= ST_FAIL;
        end
        if (cmd.scan_pick && src != 8'h00)
        begin
            found_list[got_reg[LIST_AW-1:0]] <= UNIT_W'({byte_cnt_reg[MAP_AW-1:0], pos});
            work_reg <= src & ~(8'h1 << pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            got_reg      <= '0;
            emit_idx_reg <= '0;
            first_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                byte_cnt_reg <= '0;
                got_reg      <= '0;
                emit_idx_reg <= '0;
            end
            else if (cmd.clear_wr)
            begin
                byte_cnt_reg <= CNT_W'(byte_cnt_reg + 1'b1);
            end
            else if (cmd.scan_rd)
            begin
                first_reg <= 1'b1;
            end
            else if (cmd.scan_pick)
            begin
                if (src == 8'h00)
                begin
                    byte_cnt_reg <= CNT_W'(byte_cnt_reg + 1'b1);
                end
                else
                begin
                    got_reg   <= COUNT_W'(got_reg + 1'b1);
                    first_reg <= 1'b0;
                end
            end
            else if (cmd.commit_wr)
            begin
                emit_idx_reg <= COUNT_W'(emit_idx_reg + 1'b1);
            end
            else if (cmd.fail_set)
            begin
                got_reg <= '0;
            end
        end
    end

    // Result register, one-cycle strobe
    logic        result_valid_reg;
    bba_result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.commit_wr || cmd.emit_single;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_wr)
        begin
            result_reg.unit_index <= INDEX_W'(entry) + INDEX_W'(base_reg);
            result_reg.status     <= ST_OK;
            result_reg.last       <= stat.last_unit;
        end
        else if (cmd.emit_single)
        begin
            result_reg.unit_index <= '0;
            result_reg.status     <= status_reg;
            result_reg.last       <= 1'b1;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Status to controller
    always_comb
    begin
        stat.clear_done = byte_cnt_reg[MAP_AW-1:0] == MAP_AW'(MAP_BYTES - 1);
        stat.req_write  = request.opcode == OP_WRITE;
        stat.req_zero   = request.request_count == '0;
        stat.req_over   = 32'(request.request_count) > MAX_REQUEST;
        stat.scan_end   = byte_cnt_reg >= limit_bytes_reg;
        stat.byte_empty = src == 8'h00;
        stat.req_met    = COUNT_W'(got_reg + 1'b1) == want_reg;
        stat.last_unit  = COUNT_W'(emit_idx_reg + 1'b1) == got_reg;
    end

endmodule : bba_datapath

`default_nettype wire

// File: design/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator over a one-bit-per-unit free map.
// ----------------------------------------------------------------------------
//  channel   signals                              transaction when
//  --------  -----------------------------------  ---------------------------
//  item      start, busy, request                 start && !busy
//  result    result_valid, result                 result_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index,     cfg_valid && cfg_ready
//            cfg_data
//
//  A map byte write completes in the accepting cycle. An allocate reads each
//  map byte visited and picks free units from it, then commits each unit found
//  (read-modify-write of its map byte) and shows one result per unit.
//  After reset the map is swept to zero, one byte a cycle, with busy high;
//  config transactions are taken throughout.
//  Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAP_BYTES   = MAP_BYTES_DEF,
    parameter int MAX_REQUEST = MAX_REQUEST_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // item channel
    input  wire logic              start,
    output logic                   busy,
    input  wire bba_item_t         request,
    // result channel
    output logic                   result_valid,
    output bba_result_t            result,
    // configuration channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data
);

    bba_cmd_t  cmd;
    bba_stat_t stat;

    // Settings registers always take a write
    assign cfg_ready = 1'b1;

    // Sequencer: clear sweep, byte scan, commit of found units
    bba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Map memory, scanner and result register
    bba_datapath #(
        .MAP_BYTES   (MAP_BYTES),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule : bitmap_block_allocator

`default_nettype wire

// File: tb/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Watches the item, result and register channels of the allocator, keeps its
// own copy of the free map and registers, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bba_checker
    import bba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire bba_item_t         request,
    input  wire logic              result_valid,
    input  wire bba_result_t       result,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data,
    output int                     mismatches,
    output int                     owed
);

    logic [7:0]        unit_map [MAP_BYTES_DEF];
    logic [CFG_DW-1:0] usable_lim;
    logic              skip_root;
    logic              base_add;
    bba_result_t       owed_results [$];

    // First-fit search; the map only changes when the whole request fits.
    task automatic grant_units(input logic [COUNT_W-1:0] want);
        logic [UNIT_W-1:0]  picks [MAX_REQUEST_DEF];
        logic [INDEX_W-1:0] idx;
        bba_result_t        r;
        int unsigned        lim;
        int unsigned        u;
        int unsigned        got;
        r   = '0;
        got = 0;
        if (want == 0) begin
            r.status = ST_OK;
            r.last   = 1'b1;
            owed_results.push_back(r);
        end
        else if (want > MAX_REQUEST_DEF) begin
            r.status = ST_FAIL;
            r.last   = 1'b1;
            owed_results.push_back(r);
        end
        else begin
            lim = usable_lim;
            if (lim > MAP_BYTES_DEF * 8)
                lim = MAP_BYTES_DEF * 8;
            u = skip_root ? 1 : 0;
            while (u < lim && got < want) begin
                if (unit_map[u / 8] == FULL_BYTE)
                    u = (u | 7) + 1;
                else
                begin
                    if (!unit_map[u / 8][u % 8])
                    begin
                        picks[got] = UNIT_W'(u);
                        got++;
                    end
                    u++;
                end
            end
            if (got < want) begin
                r.status = ST_FAIL;
                r.last   = 1'b1;
                owed_results.push_back(r);
            end
            else
            begin
                for (int k = 0; k < got; k++)
                begin
                    unit_map[picks[k] / 8][picks[k] % 8] = 1'b1;
                    idx          = INDEX_W'(picks[k]);
                    r.unit_index = idx + INDEX_W'(base_add);
                    r.status     = ST_OK;
                    r.last       = (k == got - 1);
                    owed_results.push_back(r);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bba_result_t want_r;
        if (!rst_n)
        begin
            foreach (unit_map[i])
                unit_map[i] = '0;
            usable_lim = USABLE_RST;
            skip_root  = RESERVE_RST;
            base_add   = BASE_RST;
            owed_results.delete();
            mismatches = 0;
            owed       = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("unexpected result: unit_index %0d status %0d last %0d",
                           result.unit_index, result.status, result.last);
                    mismatches++;
                end
                else
                begin
                    want_r = owed_results.pop_front();
                    if (result.unit_index !== want_r.unit_index)
                    begin
                        $error("unit_index: expected %0d, actual %0d",
                               want_r.unit_index, result.unit_index);
                        mismatches++;
                    end
                    if (result.status !== want_r.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want_r.status, result.status);
                        mismatches++;
                    end
                    if (result.last !== want_r.last)
                    begin
                        $error("last: expected %0d, actual %0d",
                               want_r.last, result.last);
                        mismatches++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_USABLE:  usable_lim = cfg_data;
                    CFG_RESERVE: skip_root  = cfg_data[0];
                    CFG_BASE:    base_add   = cfg_data[0];
                    default:     ;
                endcase
            end

            if (start && !busy)
            begin
                if (request.opcode == OP_WRITE)
                    unit_map[request.byte_address] = request.byte_value;
                else
                    grant_units(request.request_count);
            end

            owed = owed_results.size();
        end
    end

endmodule : bba_checker

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives map writes, allocate requests and register writes into the bitmap
// block allocator; a checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import bba_pkg::*;

    // Quiet cycles allowed before the run is called hung. The worst honest
    // stretch is the post-reset sweep or a failing scan of the whole map.
    localparam int IDLE_LIMIT   = 40000;
    localparam int RANDOM_ITEMS = 84;
    localparam int PHASES       = 7;
    // Index with no register behind it; the block must ignore the write.
    localparam logic [CFG_IW-1:0] CFG_NONE = 2'd3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    bba_item_t         request   = '0;
    logic              result_valid;
    bba_result_t       result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    int                mismatch_count;
    int                owed_count;
    int unsigned       quiet_cycles = 0;
    logic [CFG_DW-1:0] usable_set   = USABLE_RST;
    bit                eager        = 1'b0;

    bitmap_block_allocator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bba_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatch_count),
        .owed         (owed_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: any transaction on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == IDLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // All driving tasks are entered and left on a falling edge. start is
    // left high on return so that a zero gap gives back-to-back transactions
    // without ever dropping the strobe within one time step.
    task automatic issue(input bba_item_t it);
        int gap;
        gap = eager ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_byte(input logic [ADDR_W-1:0] addr, input logic [7:0] val);
        bba_item_t it;
        it              = '0;
        it.opcode       = OP_WRITE;
        it.byte_address = addr;
        it.byte_value   = val;
        issue(it);
    endtask

    task automatic allocate(input logic [COUNT_W-1:0] n);
        bba_item_t it;
        it               = '0;
        it.opcode        = OP_ALLOC;
        it.request_count = n;
        issue(it);
    endtask

    // Registers may only change with nothing in flight. A map write finishes
    // in its accepting cycle, so a short pause after the last result will do.
    task automatic settle();
        start <= 1'b0;
        while (owed_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it once the burst is done.
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [CFG_DW-1:0] usable,
                                input logic [CFG_DW-1:0] reserve,
                                input logic [CFG_DW-1:0] base);
        write_reg(CFG_USABLE, usable);
        write_reg(CFG_RESERVE, reserve);
        write_reg(CFG_BASE, base);
        cfg_valid  <= 1'b0;
        usable_set  = usable;
    endtask

    // Random item: writes mostly land in the low bytes that allocations use,
    // with now and then a stray address anywhere in the map. Empty and full
    // bytes are favoured so free space keeps coming back and full-byte skips
    // get exercised.
    function automatic bba_item_t random_item(input int unsigned span);
        bba_item_t   it;
        int unsigned pick;
        it.opcode = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_ALLOC;
        if ($urandom_range(0, 7) == 0)
            it.byte_address = ADDR_W'($urandom);
        else
            it.byte_address = ADDR_W'($urandom_range(0, span));
        pick = $urandom_range(0, 5);
        if (pick == 0)
            it.byte_value = 8'h00;
        else if (pick == 1)
            it.byte_value = FULL_BYTE;
        else
            it.byte_value = 8'($urandom);
        // mostly 1..12; now and then a zero or a count of 12..15 (13..15 oversized)
        pick = $urandom_range(0, 15);
        if (pick < 11)
            it.request_count = COUNT_W'($urandom_range(1, MAX_REQUEST_DEF));
        else if (pick == 11)
            it.request_count = '0;
        else
            it.request_count = COUNT_W'(pick);
        return it;
    endfunction

    initial
    begin
        int unsigned span;
        int unsigned pick;
        logic [CFG_DW-1:0] usable;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // Registers are taken during the post-reset sweep; the stray index
        // must leave everything alone.
        write_reg(CFG_NONE, 16'hFFFF);
        apply_config(USABLE_RST, 16'd1, 16'd0);

        allocate(4'd0);                 // zero request: plain success
        allocate(4'd15);                // oversized requests fail at once
        allocate(4'd13);
        allocate(4'd1);                 // unit 0 reserved, so unit 1
        allocate(4'd12);                // units 2..13
        write_byte(12'd2, FULL_BYTE);   // whole byte taken, scan skips it
        write_byte(12'd3, 8'h5A);
        allocate(4'd12);
        write_byte(12'hFFF, FULL_BYTE); // address extremes
        write_byte(12'hAAA, 8'h55);
        write_byte(12'h555, 8'hAA);
        write_byte(12'd0, 8'h00);       // give the low units back
        allocate(4'd12);

        // no usable unit at all
        settle();
        apply_config(16'd0, 16'd0, 16'd1);
        allocate(4'd1);

        // a single usable unit, handed out with base 1, then exhausted
        settle();
        apply_config(16'd1, 16'd0, 16'd1);
        write_byte(12'd0, 8'h00);
        allocate(4'd1);
        allocate(4'd1);

        // limit just past one byte: exactly fits, then too few free
        settle();
        apply_config(16'd9, 16'd1, 16'd1);
        write_byte(12'd0, 8'h00);
        write_byte(12'd1, 8'h00);
        allocate(4'd8);
        allocate(4'd1);

        // limit beyond the map acts as the map size
        settle();
        apply_config(16'hFFFF, 16'd1, 16'd0);
        allocate(4'd12);

        // ---- random part ----
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            pick = $urandom_range(0, 9);
            case (pick)
                0:       usable = '0;
                1:       usable = USABLE_RST;
                2:       usable = 16'hFFFF;
                3:       usable = CFG_DW'($urandom);
                default: usable = CFG_DW'($urandom_range(1, 320));
            endcase
            apply_config(usable, CFG_DW'($urandom), CFG_DW'($urandom));
            // one phase at full rate, and now and then another
            eager = (ph == 1) || ($urandom_range(0, 3) == 0);
            span  = usable_set >> 3;
            if (span > 40)
                span = 40;
            for (int n = 0; n < RANDOM_ITEMS / PHASES + 1; n++)
                issue(random_item(span));
        end

        // ---- drain and verdict ----
        start <= 1'b0;
        while (owed_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && owed_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule : testbench
